### hdl/tfcm_pkg.sv
// ----------------------------------------------------------------------------
// Thermal false colour mapper: shared package
// Types, codes and constants used by the controller and the datapath.
// ----------------------------------------------------------------------------
package tfcm_pkg;

    // Field widths fixed by the interface.
    localparam int TEMP_W     = 16;
    localparam int ADDR_W     = 8;
    localparam int COLOUR_W   = 24;
    localparam int DEG_W      = 10;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_INDEX_W = 1;

    // Divider: 19 quotient bits, 3 for the gradient segment, 16 for the fraction.
    localparam int DIV_W  = 19;
    localparam int FRAC_W = 16;
    localparam int STEP_W = 5;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_LOW_LIMIT  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_HIGH_LIMIT = 1'b1;

    // Reset values of the limits, 1/64 degree units.
    localparam logic signed [TEMP_W-1:0] LOW_LIMIT_RESET  = 16'sd320;
    localparam logic signed [TEMP_W-1:0] HIGH_LIMIT_RESET = 16'sd3200;

    // Start values of the running frame extremes, whole degrees.
    localparam logic signed [DEG_W-1:0] MIN_START = 10'sd100;
    localparam logic signed [DEG_W-1:0] MAX_START = 10'sd0;

    // One gradient stop, one bit per channel: {blue, green, red}.
    typedef logic [2:0] stop_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_DIVIDE,
        ST_FINISH
    } state_t;

    typedef enum logic [1:0] {
        CLS_BLACK,
        CLS_WHITE,
        CLS_GRADIENT
    } colour_class_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_input;
        logic setup;
        logic div_step;
        logic load_output;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic gradient;
        logic div_last;
    } dp_status_t;

    // Gradient stops: black, blue, green, yellow, red, magenta, white.
    function automatic stop_t stop_colour(input logic [2:0] idx);
        stop_t s;
        case (idx)
            3'd0:    s = 3'b000;
            3'd1:    s = 3'b100;
            3'd2:    s = 3'b010;
            3'd3:    s = 3'b011;
            3'd4:    s = 3'b001;
            3'd5:    s = 3'b101;
            default: s = 3'b111;
        endcase
        return s;
    endfunction

endpackage

### hdl/tfcm_ctrl.sv
// ----------------------------------------------------------------------------
// Thermal false colour mapper: controller
// Sequences one pixel request through setup, division (gradient pixels only)
// and result load, and owns the output valid flag.
// ----------------------------------------------------------------------------
module tfcm_ctrl
    import tfcm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    output logic       out_valid,
    input  logic       out_stall,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    // The output register can take a new result when empty or being drained.
    assign out_free = !out_valid_reg || !out_stall;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                state_next = status.gradient ? ST_DIVIDE : ST_FINISH;
            end
            ST_DIVIDE:
            begin
                if (status.div_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs and datapath commands.
    always_comb
    begin
        cmd            = '0;
        in_stall       = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall       = 1'b0;
                cmd.load_input = in_valid;
            end
            ST_SETUP:
            begin
                cmd.setup = 1'b1;
            end
            ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
            end
            ST_FINISH:
            begin
                cmd.load_output = out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    // Output valid flag follows loads and downstream takes.
    assign out_valid_next = cmd.load_output ? 1'b1 : (out_valid_reg && out_stall);
    assign out_valid      = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### hdl/tfcm_datapath.sv
// ----------------------------------------------------------------------------
// Thermal false colour mapper: datapath
// Limit registers, gradient position divider, colour ramp, rotated address
// counters, frame extremes and the output register.
// ----------------------------------------------------------------------------
module tfcm_datapath
    import tfcm_pkg::*;
#(
    parameter int COLUMNS = 16,
    parameter int ROWS    = 12
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [CFG_INDEX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data,
    input  logic signed [TEMP_W-1:0]      temperature,
    input  dp_cmd_t                       cmd,
    output dp_status_t                    status,
    output logic [ADDR_W-1:0]             pixel_address,
    output logic [COLOUR_W-1:0]           colour,
    output logic signed [DEG_W-1:0]       frame_min,
    output logic signed [DEG_W-1:0]       frame_max,
    output logic                          frame_end
);

    localparam int CW     = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int RW     = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int AW     = $clog2(ROWS * COLUMNS);
    localparam int ADDR_X = (AW > ADDR_W) ? AW : ADDR_W;

    // Limit registers.
    logic signed [TEMP_W-1:0] low_limit_reg;
    logic signed [TEMP_W-1:0] high_limit_reg;

    // Working registers of the pixel being processed.
    logic signed [TEMP_W-1:0] temp_reg;
    colour_class_t            class_reg;
    colour_class_t            class_next;
    logic [FRAC_W-1:0]        range_reg;
    logic [FRAC_W-1:0]        rem_reg;
    logic [FRAC_W-1:0]        rem_next;
    logic [DIV_W-1:0]         quo_reg;
    logic [DIV_W-1:0]         quo_next;
    logic [STEP_W-1:0]        step_reg;
    logic [STEP_W-1:0]        step_next;

    // Frame position and extremes.
    logic [CW-1:0]            col_reg;
    logic [CW-1:0]            col_next;
    logic [RW-1:0]            row_reg;
    logic [RW-1:0]            row_next;
    logic [AW-1:0]            base_reg;
    logic [AW-1:0]            base_next;
    logic signed [DEG_W-1:0]  min_reg;
    logic signed [DEG_W-1:0]  min_next;
    logic signed [DEG_W-1:0]  max_reg;
    logic signed [DEG_W-1:0]  max_next;

    // Output register.
    logic [ADDR_W-1:0]        pixel_address_reg;
    logic [COLOUR_W-1:0]      colour_reg;
    logic signed [DEG_W-1:0]  frame_min_reg;
    logic signed [DEG_W-1:0]  frame_max_reg;
    logic                     frame_end_reg;

    // Setup stage signals.
    logic                     is_black;
    logic                     is_white;
    logic [TEMP_W:0]          diff_full;
    logic [TEMP_W:0]          range_full;
    logic [DIV_W-1:0]         num;

    // Divider step signals.
    logic [FRAC_W:0]          trial;
    logic [FRAC_W:0]          trial_sub;
    logic                     trial_ge;

    // Colour ramp signals.
    logic [2:0]               seg;
    logic [FRAC_W-1:0]        frac;
    stop_t                    stop_lo;
    stop_t                    stop_hi;
    logic [23:0]              prod_up;
    logic [FRAC_W:0]          weight_dn;
    logic [24:0]              prod_dn;
    logic [7:0]               ramp_up;
    logic [7:0]               ramp_dn;
    logic [7:0]               chan [3];
    logic [COLOUR_W-1:0]      colour_sel;

    // Address and extremes signals.
    logic                     last_pixel;
    logic [ADDR_X-1:0]        addr_full;
    logic signed [DEG_W-1:0]  temp_deg;
    logic signed [TEMP_W-1:0] min_scaled;
    logic signed [TEMP_W-1:0] max_scaled;
    logic signed [DEG_W-1:0]  min_upd;
    logic signed [DEG_W-1:0]  max_upd;

    // Configuration writes; an index outside the list is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_limit_reg  <= LOW_LIMIT_RESET;
            high_limit_reg <= HIGH_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_LOW_LIMIT:  low_limit_reg  <= $signed(cfg_data);
                REG_HIGH_LIMIT: high_limit_reg <= $signed(cfg_data);
                default:        ;
            endcase
        end
    end

    // Clamp tests and the scaled position numerator (t - low) * 6.
    assign is_black   = (temp_reg <= low_limit_reg);
    assign is_white   = (temp_reg >= high_limit_reg);
    assign diff_full  = {temp_reg[TEMP_W-1], temp_reg} - {low_limit_reg[TEMP_W-1], low_limit_reg};
    assign range_full = {high_limit_reg[TEMP_W-1], high_limit_reg}
                      - {low_limit_reg[TEMP_W-1], low_limit_reg};
    assign num        = {1'b0, diff_full[FRAC_W-1:0], 2'b00}
                      + {2'b00, diff_full[FRAC_W-1:0], 1'b0};

    always_comb
    begin
        if (is_black)
        begin
            class_next = CLS_BLACK;
        end
        else if (is_white)
        begin
            class_next = CLS_WHITE;
        end
        else
        begin
            class_next = CLS_GRADIENT;
        end
    end

    // One restoring division step. The dividend is num * 65536; its top
    // sixteen bits are already below the range, so they preload the remainder.
    assign trial     = {rem_reg, quo_reg[DIV_W-1]};
    assign trial_sub = trial - {1'b0, range_reg};
    assign trial_ge  = (trial >= {1'b0, range_reg});

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        step_next = step_reg;
        if (cmd.setup)
        begin
            rem_next  = num[DIV_W-1:3];
            quo_next  = {num[2:0], {FRAC_W{1'b0}}};
            step_next = '0;
        end
        else if (cmd.div_step)
        begin
            rem_next  = trial_ge ? trial_sub[FRAC_W-1:0] : trial[FRAC_W-1:0];
            quo_next  = {quo_reg[DIV_W-2:0], trial_ge};
            step_next = step_reg + 1'b1;
        end
    end

    assign status.gradient = !is_black && !is_white;
    assign status.div_last = (step_reg == STEP_W'(DIV_W - 1));

    // Working registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load_input)
        begin
            temp_reg <= temperature;
        end
        if (cmd.setup)
        begin
            class_reg <= class_next;
            range_reg <= range_full[FRAC_W-1:0];
        end
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        step_reg <= step_next;
    end

    // Colour ramp between the two stops of the segment.
    assign seg       = quo_reg[DIV_W-1:FRAC_W];
    assign frac      = quo_reg[FRAC_W-1:0];
    assign stop_lo   = stop_colour(seg);
    assign stop_hi   = stop_colour(seg + 3'd1);
    assign prod_up   = 24'(frac) * 24'd255;
    assign weight_dn = 17'h10000 - {1'b0, frac};
    assign prod_dn   = 25'(weight_dn) * 25'd255;
    assign ramp_up   = prod_up[23:16];
    assign ramp_dn   = prod_dn[23:16];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            if (stop_lo[k] == stop_hi[k])
            begin
                chan[k] = {8{stop_lo[k]}};
            end
            else if (stop_hi[k])
            begin
                chan[k] = ramp_up;
            end
            else
            begin
                chan[k] = ramp_dn;
            end
        end
    end

    always_comb
    begin
        case (class_reg)
            CLS_BLACK:    colour_sel = '0;
            CLS_WHITE:    colour_sel = '1;
            CLS_GRADIENT: colour_sel = {chan[2], chan[1], chan[0]};
            default:      colour_sel = '0;
        endcase
    end

    // Rotated address: column * COLUMNS + (COLUMNS - 1 - row), base tracks the product.
    assign last_pixel = (row_reg == RW'(COLUMNS - 1)) && (col_reg == CW'(ROWS - 1));
    assign addr_full  = ADDR_X'(base_reg) + ADDR_X'(COLUMNS - 1) - ADDR_X'(row_reg);

    // Whole degrees, truncated toward zero.
    assign temp_deg   = $signed(temp_reg[TEMP_W-1:6])
                      + $signed({{(DEG_W-1){1'b0}}, temp_reg[TEMP_W-1] && (|temp_reg[5:0])});
    assign min_scaled = $signed({min_reg, 6'b000000});
    assign max_scaled = $signed({max_reg, 6'b000000});
    assign min_upd    = (min_scaled > temp_reg) ? temp_deg : min_reg;
    assign max_upd    = (max_scaled < temp_reg) ? temp_deg : max_reg;

    // Frame position and extremes advance when a result is loaded.
    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        base_next = base_reg;
        min_next  = min_reg;
        max_next  = max_reg;
        if (cmd.load_output)
        begin
            if (last_pixel)
            begin
                col_next  = '0;
                row_next  = '0;
                base_next = '0;
                min_next  = MIN_START;
                max_next  = MAX_START;
            end
            else
            begin
                min_next = min_upd;
                max_next = max_upd;
                if (col_reg == CW'(ROWS - 1))
                begin
                    col_next  = '0;
                    base_next = '0;
                    row_next  = row_reg + 1'b1;
                end
                else
                begin
                    col_next  = col_reg + 1'b1;
                    base_next = base_reg + AW'(COLUMNS);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            base_reg <= '0;
            min_reg  <= MIN_START;
            max_reg  <= MAX_START;
        end
        else
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            base_reg <= base_next;
            min_reg  <= min_next;
            max_reg  <= max_next;
        end
    end

    // Output register.
    always_ff @(posedge clk)
    begin
        if (cmd.load_output)
        begin
            pixel_address_reg <= addr_full[ADDR_W-1:0];
            colour_reg        <= colour_sel;
            frame_min_reg     <= min_upd;
            frame_max_reg     <= max_upd;
            frame_end_reg     <= last_pixel;
        end
    end

    assign pixel_address = pixel_address_reg;
    assign colour        = colour_reg;
    assign frame_min     = frame_min_reg;
    assign frame_max     = frame_max_reg;
    assign frame_end     = frame_end_reg;

endmodule

### hdl/thermal_false_colour_mapper_core.sv
// ----------------------------------------------------------------------------
// Thermal false colour mapper core
// Maps each pixel temperature to a seven-stop false colour, a rotated
// output address and running whole-degree frame extremes.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                                   Direction  Payload
//  --------  ----------------------------------------  ---------  ----------------------
//  config    cfg_we, cfg_index, cfg_data               in         low/high limit write
//  input     in_valid, in_stall, temperature           in         one pixel temperature
//  output    out_valid, out_stall, pixel_address,      out        address, colour,
//            colour, frame_min, frame_max, frame_end              extremes, frame end
//
//  A pixel clamped to black or white skips the division; a pixel between the
//  limits passes through the 19-step radix-2 divider that finds the
//  gradient segment and fraction. One pixel is processed at a time.
//  Reset restores the limits to 320 and 3200 and starts a new frame.
//  A new request is taken while a finished result waits; a stalled output
//  holds the next result in the datapath until the output register frees.
//
module thermal_false_colour_mapper_core
    import tfcm_pkg::*;
#(
    parameter int COLUMNS = 16,
    parameter int ROWS    = 12
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CFG_INDEX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic signed [TEMP_W-1:0] temperature,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [ADDR_W-1:0]        pixel_address,
    output logic [COLOUR_W-1:0]      colour,
    output logic signed [DEG_W-1:0]  frame_min,
    output logic signed [DEG_W-1:0]  frame_max,
    output logic                     frame_end
);

    dp_cmd_t    cmd;
    dp_status_t status;

    // Sequencing.
    tfcm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // Arithmetic and storage.
    tfcm_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .temperature   (temperature),
        .cmd           (cmd),
        .status        (status),
        .pixel_address (pixel_address),
        .colour        (colour),
        .frame_min     (frame_min),
        .frame_max     (frame_max),
        .frame_end     (frame_end)
    );

endmodule

### hdl/tfcm_checker.sv
// ----------------------------------------------------------------------------
// Thermal false colour mapper: port checker
// Watches the top-level ports for sequencing and output hold behavior.
// ----------------------------------------------------------------------------
module tfcm_checker
    import tfcm_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input logic                out_valid,
    input logic                out_stall,
    input logic [ADDR_W-1:0]   pixel_address,
    input logic [COLOUR_W-1:0] colour,
    input logic                frame_end
);

    // An accepted request keeps the input side busy through setup and the state that follows it.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall ##1 in_stall)
        else $error("input side not busy after an accepted request");

    // A new result only appears after the block has been busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared without a request in work");

    // A stalled result stays valid and unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=>
            (out_valid && $stable(colour) && $stable(pixel_address) && $stable(frame_end)))
        else $error("stalled result changed");

endmodule

bind thermal_false_colour_mapper_core tfcm_checker u_tfcm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .pixel_address (pixel_address),
    .colour        (colour),
    .frame_end     (frame_end)
);
